FILE: src/ivm_pkg.sv
// ----------------------------------------------------------------------------
// ivm_pkg
// Shared types, constants and codes of the interval value map.
// ----------------------------------------------------------------------------
package ivm_pkg;

  localparam int MAX_BP   = 64;
  localparam int KEY_BITS = 32;
  localparam int VAL_BITS = 8;
  localparam int ADDR_W   = $clog2(MAX_BP);
  localparam int IDX_W    = ADDR_W + 1;
  localparam int ENT_W    = KEY_BITS + VAL_BITS;

  localparam logic       MODE_ASSIGN = 1'b0;
  localparam logic       MODE_LOOKUP = 1'b1;
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic                mode;
    logic [KEY_BITS-1:0] key_begin;
    logic [KEY_BITS-1:0] key_end;
    logic [VAL_BITS-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic [VAL_BITS-1:0] read_value;
    logic [1:0]          status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_INS_B, S_INS_E, S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit_b;
    logic emit_e;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic is_empty;
    logic at_end;
    logic inserted;
    logic ent_gt_key;
    logic ent_gt_ke;
  } sts_t;

endpackage

FILE: src/ivm_ram.sv
// ----------------------------------------------------------------------------
// ivm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ivm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ivm_ctrl.sv
// ----------------------------------------------------------------------------
// ivm_ctrl
// Controller: sequences the table scan, interval insertion and response.
// ----------------------------------------------------------------------------
module ivm_ctrl
  import ivm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.is_lookup) begin
          if (sts.at_end || sts.ent_gt_key) begin
            cmd.finish = 1'b1;
            state_nxt  = S_RESP;
          end else begin
            cmd.step = 1'b1;
          end
        end else if (sts.is_empty) begin
          cmd.finish = 1'b1;
          state_nxt  = S_RESP;
        end else if (sts.at_end) begin
          if (sts.inserted) begin
            cmd.finish = 1'b1;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_INS_B;
          end
        end else if (!sts.inserted && sts.ent_gt_ke) begin
          state_nxt = S_INS_B;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_INS_B: begin
        cmd.emit_b = 1'b1;
        state_nxt  = S_INS_E;
      end
      S_INS_E: begin
        cmd.emit_e = 1'b1;
        state_nxt  = S_SCAN;
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/ivm_dp.sv
// ----------------------------------------------------------------------------
// ivm_dp
// Datapath: ping-pong breakpoint tables, scan pointer, rebuild writer with
// canonical compression, and the response register.
// ----------------------------------------------------------------------------
module ivm_dp
  import ivm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  req_t                in_req,
  input  logic                cfg_we,
  input  logic [VAL_BITS-1:0] cfg_data,
  input  cmd_t                cmd,
  output sts_t                sts,
  output rsp_t                out_rsp,
  output logic [IDX_W-1:0]    count
);

  req_t                req_r;
  logic [VAL_BITS-1:0] dflt_r;
  logic                bank_r;
  logic [IDX_W-1:0]    cnt_r, idx_r, idx_nxt, wcnt_r;
  logic [VAL_BITS-1:0] in_force_r, end_val_r, look_r;
  logic                ins_r, full_r;
  rsp_t                rsp_r;

  logic [ENT_W-1:0]    q0, q1, ent;
  logic [KEY_BITS-1:0] ent_key;
  logic [VAL_BITS-1:0] ent_val;
  logic                em_en, em_diff, wr_en;
  logic [KEY_BITS-1:0] em_key;
  logic [VAL_BITS-1:0] em_val;
  logic                is_lookup, copy_ent, track_end;

  // current table entry from the active bank
  assign ent     = bank_r ? q1 : q0;
  assign ent_key = ent[ENT_W-1 -: KEY_BITS];
  assign ent_val = ent[VAL_BITS-1:0];

  assign is_lookup = (req_r.mode == MODE_LOOKUP);

  // status to the controller
  assign sts.is_lookup  = is_lookup;
  assign sts.is_empty   = !(req_r.key_begin < req_r.key_end);
  assign sts.at_end     = (idx_r == cnt_r);
  assign sts.inserted   = ins_r;
  assign sts.ent_gt_key = (ent_key > req_r.key_begin);
  assign sts.ent_gt_ke  = (ent_key > req_r.key_end);

  // address the next entry so read data lines up with idx_r
  always_comb begin
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.step) begin
      idx_nxt = idx_r + IDX_W'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  // pick what goes to the rebuild writer; every entry ahead of the insertion
  // point may set the value in force at key_end
  assign copy_ent  = cmd.step && !is_lookup && (ins_r || (ent_key < req_r.key_begin));
  assign track_end = cmd.step && !is_lookup && !ins_r;

  always_comb begin
    em_en  = 1'b0;
    em_key = ent_key;
    em_val = ent_val;
    if (cmd.emit_b) begin
      em_en  = 1'b1;
      em_key = req_r.key_begin;
      em_val = req_r.new_value;
    end else if (cmd.emit_e) begin
      em_en  = 1'b1;
      em_key = req_r.key_end;
      em_val = end_val_r;
    end else if (copy_ent) begin
      em_en = 1'b1;
    end
  end

  // drop entries equal to the value already in force
  assign em_diff = em_en && (em_val != in_force_r);
  assign wr_en   = em_diff && (wcnt_r != IDX_W'(MAX_BP));

  ivm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BP)) u_bank0 (
    .clk   (clk),
    .we    (wr_en && bank_r),
    .waddr (wcnt_r[ADDR_W-1:0]),
    .wdata ({em_key, em_val}),
    .raddr (idx_nxt[ADDR_W-1:0]),
    .rdata (q0)
  );

  ivm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BP)) u_bank1 (
    .clk   (clk),
    .we    (wr_en && !bank_r),
    .waddr (wcnt_r[ADDR_W-1:0]),
    .wdata ({em_key, em_val}),
    .raddr (idx_nxt[ADDR_W-1:0]),
    .rdata (q1)
  );

  // control state: default value, active bank, entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r <= '0;
      bank_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        dflt_r <= cfg_data;
      end
      if (cmd.finish && !is_lookup && !sts.is_empty && !full_r) begin
        bank_r <= !bank_r;
        cnt_r  <= wcnt_r;
      end
    end
  end

  // per-request working registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      req_r      <= in_req;
      wcnt_r     <= '0;
      in_force_r <= dflt_r;
      end_val_r  <= dflt_r;
      look_r     <= dflt_r;
      ins_r      <= 1'b0;
      full_r     <= 1'b0;
    end else begin
      if (wr_en) begin
        wcnt_r     <= wcnt_r + IDX_W'(1);
        in_force_r <= em_val;
      end
      if (em_diff && !wr_en) begin
        full_r <= 1'b1;
      end
      if (track_end && (ent_key <= req_r.key_end)) begin
        end_val_r <= ent_val;
      end
      if (cmd.step && is_lookup) begin
        look_r <= ent_val;
      end
      if (cmd.emit_e) begin
        ins_r <= 1'b1;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (is_lookup) begin
        rsp_r <= '{read_value: look_r, status: ST_DONE};
      end else if (sts.is_empty) begin
        rsp_r <= '{read_value: '0, status: ST_EMPTY};
      end else if (full_r) begin
        rsp_r <= '{read_value: '0, status: ST_FULL};
      end else begin
        rsp_r <= '{read_value: '0, status: ST_DONE};
      end
    end
  end

  assign out_rsp = rsp_r;
  assign count   = cnt_r;

endmodule

FILE: src/interval_value_map_unit.sv
// A lookup scans the breakpoints in order up to the first one above the key;
// an assign makes one pass over the active table plus the begin and end
// insertion states, and an empty interval finishes without a scan.
// Throughput: one request at a time; the table scan through a one-read RAM
// sets the rate. Synchronous active-low reset clears the table (count zero),
// the default value and the controller; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// interval_value_map_unit
// Piecewise-constant key to value map with interval assign and lookup.
// ----------------------------------------------------------------------------
module interval_value_map_unit
  import ivm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  req_t                in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output rsp_t                out_rsp,
  input  logic                cfg_we,
  input  logic [VAL_BITS-1:0] cfg_data
);

  cmd_t             cmd;
  sts_t             sts;
  logic [IDX_W-1:0] count;

  ivm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ivm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_rsp  (out_rsp),
    .count    (count)
  );

`ifndef SYNTHESIS
  // no new request while a response is pending
  a_busy_while_resp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request accepted while response pending");

  // table never grows past capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count <= IDX_W'(MAX_BP))
    else $error("entry count over capacity");

  // a response always carries a defined status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.status == ST_DONE || out_rsp.status == ST_EMPTY ||
                   out_rsp.status == ST_FULL))
    else $error("bad status code");
`endif

endmodule
